// ----- sv/krle_pkg.sv -----
// ----------------------------------------------------------------------------
// krle_pkg
// Shared types, command codes, register indexes and the decay table for the
// key ripple light effect.
// ----------------------------------------------------------------------------
package krle_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned KeyW   = 7;
  localparam int unsigned PosW   = 13;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LevelW = 8;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ColW   = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 24;

  // Default sizes.
  localparam int unsigned MAX_KEYS    = 128;
  localparam int unsigned PRESS_SLOTS = 16;
  localparam int unsigned EXP_ENTRIES = 256;
  localparam int unsigned ExpMax      = 1024;
  localparam int unsigned ExpIdxW     = 10;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CmdW-1:0] CMD_PRESS  = 2'd1;
  localparam logic [CmdW-1:0] CMD_RENDER = 2'd2;
  localparam logic [CmdW-1:0] CMD_NONE   = 2'd3;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] REG_RING_SPEED  = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_DECAY_RATE  = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_THICKNESS   = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_SCALE       = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_RIPPLE      = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_BASE        = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_WINDOW      = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_KEY_COUNT   = 4'd7;

  localparam logic [12:0] MIN_THICK = 13'd20;
  localparam logic [64:0] EXP_STEP  = 65'd4162825044;

  // One queued item.
  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [KeyW-1:0]   key;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
    logic [TimeW-1:0]  now;
    logic [LevelW-1:0] level;
  } item_t;

  // Register file as seen by the datapath.
  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] decay_rate;
    logic [12:0] thick;
    logic [11:0] scale;
    logic [23:0] ripple;
    logic [23:0] base;
    logic [15:0] window;
    logic [7:0]  count;
  } cfg_t;

  typedef logic [16:0] exp_tab_t [ExpMax];

  // exp(-i/32) in Q.16, built by repeated rounded multiplication in Q.32.
  function automatic exp_tab_t build_exp();
    exp_tab_t    tab;
    logic [64:0] acc;
    logic [64:0] prod;
    acc = 65'd1 << 32;
    for (int i = 0; i < ExpMax; i++) begin
      tab[i] = 17'((acc + 65'd32768) >> 16);
      prod   = acc * EXP_STEP;
      acc    = (prod + (65'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

endpackage

// ----- sv/krle_front.sv -----
// ----------------------------------------------------------------------------
// krle_front
// Accepts input items, drops those that do nothing and queues the rest.
// ----------------------------------------------------------------------------
module krle_front #(
  parameter int unsigned MaxKeys = krle_pkg::MAX_KEYS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  krle_pkg::item_t             in_item_i,
  input  logic [7:0]                  count_i,
  output krle_pkg::item_t             item_o,
  output logic                        item_vld_o,
  input  logic                        pop_i
);
  import krle_pkg::*;

  item_t      fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       keep, push, full;

  // Classify the item: only useful commands go into the queue.
  always_comb begin
    keep = 1'b0;
    case (in_item_i.cmd)
      CMD_LOAD:   keep = ({1'b0, in_item_i.key} < 8'(MaxKeys));
      CMD_PRESS:  keep = ({1'b0, in_item_i.key} < count_i);
      CMD_RENDER: keep = ({1'b0, in_item_i.key} < count_i);
      default:    keep = 1'b0;
    endcase
  end

  assign full       = (cnt_q == 2'd2);
  assign in_stall_o = full;
  assign push       = in_valid_i && !full && keep;
  assign item_o     = fifo_q[rp_q];
  assign item_vld_o = (cnt_q != 2'd0);

  // Two-entry queue between the front and the back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= in_item_i;
    end
  end

endmodule

// ----- sv/krle_back.sv -----
// ----------------------------------------------------------------------------
// krle_back
// Executes queued items: position loads, press recording and the render
// sequencer with its square root, divider and multiply steps.
// ----------------------------------------------------------------------------
module krle_back #(
  parameter int unsigned MaxKeys    = krle_pkg::MAX_KEYS,
  parameter int unsigned PressSlots = krle_pkg::PRESS_SLOTS,
  parameter int unsigned ExpEntries = krle_pkg::EXP_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  krle_pkg::cfg_t              cfg_i,
  input  krle_pkg::item_t             item_i,
  input  logic                        item_vld_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [krle_pkg::KeyW-1:0]   key_out_o,
  output logic [krle_pkg::ColW-1:0]   red_o,
  output logic [krle_pkg::ColW-1:0]   green_o,
  output logic [krle_pkg::ColW-1:0]   blue_o
);
  import krle_pkg::*;

  localparam int unsigned AddrW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;
  localparam int unsigned SlotW = (PressSlots > 1) ? $clog2(PressSlots) : 1;
  localparam int unsigned SumW  = 37 + $clog2(PressSlots + 1);
  localparam int unsigned ChW   = SumW + 10;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(PressSlots - 1);
  localparam exp_tab_t ExpTab = build_exp();

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RKEY  = 4'd1;
  localparam logic [3:0] S_SLOT  = 4'd2;
  localparam logic [3:0] S_SDIST = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_SDIFF = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_MUL1  = 4'd7;
  localparam logic [3:0] S_MUL2  = 4'd8;
  localparam logic [3:0] S_MUL3  = 4'd9;
  localparam logic [3:0] S_CHAN  = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  // Key position memory.
  logic [2*PosW-1:0] pos_mem [MaxKeys];
  logic [2*PosW-1:0] rd_q;
  logic              mem_we;
  logic [AddrW-1:0]  raddr;

  // Press ring.
  logic              rv_q [PressSlots];
  logic [KeyW-1:0]   rk_q [PressSlots];
  logic [TimeW-1:0]  rt_q [PressSlots];
  logic [LevelW-1:0] rl_q [PressSlots];
  logic [SlotW-1:0]  head_q;
  logic              ring_we;

  // Sequencer state.
  logic [3:0]        state_q, state_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [PosW-1:0]   kx_q, kx_d, ky_q, ky_d;
  logic [15:0]       age_q, age_d;
  logic [26:0]       v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic [27:0]       radius_q, radius_d;
  logic [20:0]       idx_q, idx_d;
  logic [13:0]       rem_q, rem_d;
  logic [16:0]       quo_q, quo_d;
  logic [32:0]       p1_q, p1_d;
  logic [24:0]       p2_q, p2_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [1:0]        ch_q, ch_d;
  logic [ColW-1:0]   rgb_q [3];
  logic [ColW-1:0]   rgb_d [3];
  logic              out_vld_q, out_vld_d, out_load;
  logic [KeyW-1:0]   key_out_q;
  logic [ColW-1:0]   red_q, green_q, blue_q;

  // Datapath helpers.
  logic [TimeW-1:0]  age_full;
  logic              slot_live;
  logic signed [13:0] dx, dy;
  logic [27:0]       sq_x, sq_y;
  logic [27:0]       sq_t;
  logic [13:0]       root_val, trial;
  logic [27:0]       diff;
  logic [16:0]       dec;
  logic [7:0]        bsel, rsel;
  logic [ChW-1:0]    chv;
  logic [ChW-33:0]   chhi;

  assign age_full  = item_i.now - rt_q[slot_q];
  assign slot_live = rv_q[slot_q] && ({1'b0, rk_q[slot_q]} < cfg_i.count) &&
                     (item_i.now > rt_q[slot_q]) &&
                     (age_full <= {16'd0, cfg_i.window});
  assign dx    = $signed({1'b0, kx_q}) - $signed({1'b0, rd_q[2*PosW-1:PosW]});
  assign dy    = $signed({1'b0, ky_q}) - $signed({1'b0, rd_q[PosW-1:0]});
  assign sq_x  = 28'(dx * dx);
  assign sq_y  = 28'(dy * dy);
  assign sq_t  = {1'b0, res_q} + {1'b0, bit_q};
  assign root_val = res_q[13:0];
  assign diff  = ({14'd0, root_val} > radius_q) ? ({14'd0, root_val} - radius_q)
                                                : (radius_q - {14'd0, root_val});
  assign trial = (cnt_q == 5'd0) ? rem_q : {rem_q[12:0], 1'b0};
  assign dec   = (idx_q < 21'(ExpEntries)) ? ExpTab[idx_q[ExpIdxW-1:0]] : 17'd0;

  // Colour byte selection for the channel being computed.
  always_comb begin
    case (ch_q)
      2'd0:    begin bsel = cfg_i.base[23:16]; rsel = cfg_i.ripple[23:16]; end
      2'd1:    begin bsel = cfg_i.base[15:8];  rsel = cfg_i.ripple[15:8];  end
      default: begin bsel = cfg_i.base[7:0];   rsel = cfg_i.ripple[7:0];   end
    endcase
  end
  assign chv  = ({ChW'(bsel)} << 32) + ChW'(rsel * sum_q) + (ChW'(1) << 31);
  assign chhi = chv[ChW-1:32];

  // Sequencer next state.
  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    cnt_d    = cnt_q;
    kx_d     = kx_q;
    ky_d     = ky_q;
    age_d    = age_q;
    v_d      = v_q;
    res_d    = res_q;
    bit_d    = bit_q;
    radius_d = radius_q;
    idx_d    = idx_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    sum_d    = sum_q;
    ch_d     = ch_q;
    rgb_d    = rgb_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    ring_we  = 1'b0;
    raddr    = item_i.key[AddrW-1:0];
    out_load = 1'b0;
    out_vld_d = out_vld_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (item_vld_i) begin
          case (item_i.cmd)
            CMD_LOAD: begin
              mem_we = 1'b1;
              pop_o  = 1'b1;
            end
            CMD_PRESS: begin
              ring_we = 1'b1;
              pop_o   = 1'b1;
            end
            CMD_RENDER: begin
              sum_d   = '0;
              slot_d  = '0;
              state_d = S_RKEY;
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      S_RKEY: begin
        kx_d    = rd_q[2*PosW-1:PosW];
        ky_d    = rd_q[PosW-1:0];
        state_d = S_SLOT;
      end
      S_SLOT: begin
        raddr = rk_q[slot_q][AddrW-1:0];
        age_d = age_full[15:0];
        if (slot_live) begin
          state_d = S_SDIST;
        end else if (slot_q == LastSlot) begin
          ch_d    = 2'd0;
          state_d = S_CHAN;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      S_SDIST: begin
        v_d      = 27'(sq_x + sq_y);
        res_d    = '0;
        bit_d    = 27'd1 << 26;
        radius_d = 28'((32'(cfg_i.speed) * 32'(age_q)) >> 4);
        idx_d    = 21'((32'(cfg_i.decay_rate) * 32'(age_q)) >> 11);
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        // One root digit per cycle.
        if ({1'b0, v_q} >= sq_t) begin
          v_d   = 27'({1'b0, v_q} - sq_t);
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = S_SDIFF;
        end
      end
      S_SDIFF: begin
        if (diff > {15'd0, cfg_i.thick}) begin
          if (slot_q == LastSlot) begin
            ch_d    = 2'd0;
            state_d = S_CHAN;
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_SLOT;
          end
        end else begin
          rem_d   = 14'({15'd0, cfg_i.thick} - diff);
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (trial >= {1'b0, cfg_i.thick}) begin
          rem_d = trial - {1'b0, cfg_i.thick};
          quo_d = {quo_q[15:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[15:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd16) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        p1_d    = 33'(quo_q * dec);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        p2_d    = 25'(p1_q[32:16] * rl_q[slot_q]);
        state_d = S_MUL3;
      end
      S_MUL3: begin
        sum_d = sum_q + SumW'(p2_q * cfg_i.scale);
        if (slot_q == LastSlot) begin
          ch_d    = 2'd0;
          state_d = S_CHAN;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_SLOT;
        end
      end
      S_CHAN: begin
        rgb_d[ch_q] = (chhi > (ChW-32)'(255)) ? 8'd255 : chhi[7:0];
        ch_d = ch_q + 1'b1;
        if (ch_q == 2'd2) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          pop_o     = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      head_q    <= '0;
      for (int i = 0; i < PressSlots; i++) begin
        rv_q[i] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (ring_we) begin
        rv_q[head_q] <= 1'b1;
        head_q <= (head_q == LastSlot) ? '0 : head_q + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    cnt_q    <= cnt_d;
    kx_q     <= kx_d;
    ky_q     <= ky_d;
    age_q    <= age_d;
    v_q      <= v_d;
    res_q    <= res_d;
    bit_q    <= bit_d;
    radius_q <= radius_d;
    idx_q    <= idx_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    sum_q    <= sum_d;
    ch_q     <= ch_d;
    rgb_q    <= rgb_d;
    if (ring_we) begin
      rk_q[head_q] <= item_i.key;
      rt_q[head_q] <= item_i.now;
      rl_q[head_q] <= item_i.level;
    end
    if (out_load) begin
      key_out_q <= item_i.key;
      red_q     <= rgb_q[0];
      green_q   <= rgb_q[1];
      blue_q    <= rgb_q[2];
    end
  end

  // Position memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pos_mem[item_i.key[AddrW-1:0]] <= {item_i.pos_x, item_i.pos_y};
    end
    rd_q <= pos_mem[raddr];
  end

  assign out_valid_o = out_vld_q;
  assign key_out_o   = key_out_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

// ----- sv/key_ripple_light_effect_core.sv -----
// The back end executes and pops a load or press from its idle state. A render passes
// queue head and key read, then per press slot a liveness check that may skip it, a
// 14-step square root, a ring test that may drop it, a 17-step divider and three
// multiply steps, then three colour channels and a result load held by output stall.
// No new item is taken before a render ends; a two-entry queue takes items meanwhile.
// Reset clears the registers to their defaults, the press ring and the queue.
// ----------------------------------------------------------------------------
// key_ripple_light_effect_core
// Top level: register file, front queue and back-end render sequencer.
// ----------------------------------------------------------------------------
module key_ripple_light_effect_core #(
  parameter int unsigned MaxKeys    = krle_pkg::MAX_KEYS,
  parameter int unsigned PressSlots = krle_pkg::PRESS_SLOTS,
  parameter int unsigned ExpEntries = krle_pkg::EXP_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [krle_pkg::CmdW-1:0]     command_i,
  input  logic [krle_pkg::KeyW-1:0]     key_i,
  input  logic [krle_pkg::PosW-1:0]     pos_x_i,
  input  logic [krle_pkg::PosW-1:0]     pos_y_i,
  input  logic [krle_pkg::TimeW-1:0]    time_ms_i,
  input  logic [krle_pkg::LevelW-1:0]   press_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [krle_pkg::KeyW-1:0]     key_out_o,
  output logic [krle_pkg::ColW-1:0]     red_o,
  output logic [krle_pkg::ColW-1:0]     green_o,
  output logic [krle_pkg::ColW-1:0]     blue_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [krle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [krle_pkg::CfgDataW-1:0] cfg_data_i
);
  import krle_pkg::*;

  logic [15:0] speed_q, decay_rate_q, window_q;
  logic [12:0] thick_q;
  logic [11:0] scale_q;
  logic [23:0] ripple_q, base_q;
  logic [7:0]  key_count_q;
  cfg_t        cfg;
  item_t       in_item, item;
  logic        item_vld, pop;

  assign cfg_ready_o = 1'b1;

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q      <= 16'd66;
      decay_rate_q <= 16'd3277;
      thick_q      <= 13'd410;
      scale_q      <= 12'd256;
      ripple_q     <= 24'hFFFFFF;
      base_q       <= 24'h000000;
      window_q     <= 16'd1500;
      key_count_q  <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RING_SPEED: speed_q      <= cfg_data_i[15:0];
        REG_DECAY_RATE: decay_rate_q <= cfg_data_i[15:0];
        REG_THICKNESS:  thick_q      <= cfg_data_i[12:0];
        REG_SCALE:      scale_q      <= cfg_data_i[11:0];
        REG_RIPPLE:     ripple_q     <= cfg_data_i;
        REG_BASE:       base_q       <= cfg_data_i;
        REG_WINDOW:     window_q     <= cfg_data_i[15:0];
        REG_KEY_COUNT:  key_count_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective values: clamped thickness and key count.
  always_comb begin
    cfg.speed      = speed_q;
    cfg.decay_rate = decay_rate_q;
    cfg.thick      = (thick_q < MIN_THICK) ? MIN_THICK : thick_q;
    cfg.scale      = scale_q;
    cfg.ripple     = ripple_q;
    cfg.base       = base_q;
    cfg.window     = window_q;
    cfg.count      = (key_count_q > 8'(MaxKeys)) ? 8'(MaxKeys) : key_count_q;
  end

  assign in_item = '{cmd: command_i, key: key_i, pos_x: pos_x_i, pos_y: pos_y_i,
                     now: time_ms_i, level: press_level_i};

  krle_front #(
    .MaxKeys (MaxKeys)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .count_i    (cfg.count),
    .item_o     (item),
    .item_vld_o (item_vld),
    .pop_i      (pop)
  );

  krle_back #(
    .MaxKeys    (MaxKeys),
    .PressSlots (PressSlots),
    .ExpEntries (ExpEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (item),
    .item_vld_i  (item_vld),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_out_o   (key_out_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

`ifndef NO_ASSERTIONS
  // The back end only removes an item that is in the queue.
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> item_vld) else $error("queue popped while empty");

  // A new result only appears when a queued render has just finished.
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(item_vld) && $past(pop))
    else $error("result without a rendered item");
`endif

endmodule
